// ===== sv/colon_fragment_header_parser_assert.svh =====
// assertion macros for the colon fragment header parser
// no dependencies; included by modules that carry assertions
`ifndef COLON_FRAGMENT_HEADER_PARSER_ASSERT_SVH
`define COLON_FRAGMENT_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define CFHP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cfhp assertion failed");
`define CFHP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cfhp assertion failed");
`else
`define CFHP_ASSERT(lbl, clk, rst_n, prop)
`define CFHP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/cfhp_pkg.sv =====
// shared constants and types for the colon fragment header parser
// no dependencies; used by the channel interfaces and the top level
package cfhp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ACC_W       = 16;
  localparam int unsigned SIZE_W      = 10;
  localparam int unsigned MAX_PAYLOAD = 1000;

  localparam int unsigned ACC_PROD_W  = ACC_W + 4;
  localparam int unsigned SIZE_PROD_W = SIZE_W + 4;

  localparam logic [BYTE_W-1:0] COLON_BYTE = 8'h3A;
  localparam logic [BYTE_W-1:0] DIGIT_LO   = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT_HI   = 8'h39;
  localparam logic [ACC_W-1:0]  ACC_MAX    = {ACC_W{1'b1}};
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_PAYLOAD);

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_NAME   = 2'd1,
    KIND_DATA   = 2'd2
  } kind_t;

  typedef enum logic [5:0] {
    PH_TOTAL  = 6'b000001,
    PH_NUMBER = 6'b000010,
    PH_SIZE   = 6'b000100,
    PH_NAME   = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

endpackage

// ===== sv/cfhp_if.sv =====
// valid/ready channel interfaces for datagram bytes in and parse results out
// depends on cfhp_pkg
interface cfhp_in_if;
  logic                          valid;
  logic                          ready;
  logic [cfhp_pkg::BYTE_W-1:0]   data_byte;
  logic                          packet_start;

  modport source (output valid, data_byte, packet_start, input ready);
  modport sink   (input valid, data_byte, packet_start, output ready);
endinterface

interface cfhp_out_if;
  logic                          valid;
  logic                          ready;
  cfhp_pkg::kind_t               item_kind;
  logic [cfhp_pkg::ACC_W-1:0]    total_frags;
  logic [cfhp_pkg::ACC_W-1:0]    fragment_number;
  logic [cfhp_pkg::SIZE_W-1:0]   payload_size;
  logic                          size_clipped;
  logic [cfhp_pkg::BYTE_W-1:0]   item_byte;
  logic                          last_of_packet;

  modport source (output valid, item_kind, total_frags, fragment_number, payload_size,
                  size_clipped, item_byte, last_of_packet, input ready);
  modport sink   (input valid, item_kind, total_frags, fragment_number, payload_size,
                  size_clipped, item_byte, last_of_packet, output ready);
endinterface

// ===== sv/colon_fragment_header_parser.sv =====
// colon fragment header parser: total:number:size:name:data, one byte per beat
// depends on cfhp_pkg, cfhp_if.sv and colon_fragment_header_parser_assert.svh
//
//  channel  dir  content
//  in_ch    in   data_byte, packet_start
//  out_ch   out  item_kind, total_frags, fragment_number, payload_size,
//                size_clipped, item_byte, last_of_packet
//
// one byte accepted per cycle while in_ch.ready is high; parse state updates at the accepting edge
// a result is loaded into the output register at the edge that accepts its byte
// in_ch.ready is low only while a result is held and out_ch.ready is low
// synchronous active-low reset puts the parser in the total field, accs zero
`include "colon_fragment_header_parser_assert.svh"

module colon_fragment_header_parser (
  input  logic      clk,
  input  logic      rst_n,
  cfhp_in_if.sink   in_ch,
  cfhp_out_if.source out_ch
);
  import cfhp_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic              stop_r, stop_nxt;
  logic [ACC_W-1:0]  total_r, total_nxt;
  logic [ACC_W-1:0]  number_r, number_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic              clip_r, clip_nxt;
  logic [SIZE_W-1:0] left_r, left_nxt;

  logic              ov_r, ov_nxt;
  kind_t             okind_r, okind_nxt;
  logic [ACC_W-1:0]  ototal_r, ototal_nxt;
  logic [ACC_W-1:0]  onumber_r, onumber_nxt;
  logic [SIZE_W-1:0] osize_r, osize_nxt;
  logic              oclip_r, oclip_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;

  phase_t            e_phase;
  logic              e_stop;
  logic [ACC_W-1:0]  e_total, e_number;
  logic [SIZE_W-1:0] e_size, e_left, left_dec;
  logic              e_clip;

  logic              accept, is_colon, is_digit, emit;
  logic [BYTE_W-1:0] b;
  logic [3:0]        digit;
  logic [ACC_W-1:0]  acc_sel, acc_new;
  logic [ACC_PROD_W-1:0]  acc_prod;
  logic [SIZE_PROD_W-1:0] size_prod;
  logic [SIZE_W-1:0] size_new;
  logic              size_over;

  assign in_ch.ready = !ov_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign is_colon    = (b == COLON_BYTE);
  assign is_digit    = (b >= DIGIT_LO) && (b <= DIGIT_HI);
  assign digit       = b[3:0];

  // packet start folds the reset values into this beat
  assign e_phase  = in_ch.packet_start ? PH_TOTAL : phase_r;
  assign e_stop   = in_ch.packet_start ? 1'b0 : stop_r;
  assign e_total  = in_ch.packet_start ? '0 : total_r;
  assign e_number = in_ch.packet_start ? '0 : number_r;
  assign e_size   = in_ch.packet_start ? '0 : size_r;
  assign e_clip   = in_ch.packet_start ? 1'b0 : clip_r;
  assign e_left   = in_ch.packet_start ? '0 : left_r;
  assign left_dec = e_left - SIZE_W'(1);

  // decimal accumulate, shared by total and number
  assign acc_sel  = (e_phase == PH_NUMBER) ? e_number : e_total;
  assign acc_prod = ACC_PROD_W'(acc_sel) * ACC_PROD_W'(10) + ACC_PROD_W'(digit);
  assign acc_new  = (acc_prod > ACC_PROD_W'(ACC_MAX)) ? ACC_MAX : acc_prod[ACC_W-1:0];

  assign size_prod = SIZE_PROD_W'(e_size) * SIZE_PROD_W'(10) + SIZE_PROD_W'(digit);
  assign size_over = (size_prod > SIZE_PROD_W'(MAX_PAYLOAD));
  assign size_new  = size_over ? SIZE_MAX : size_prod[SIZE_W-1:0];

  always_comb begin
    phase_nxt   = phase_r;
    stop_nxt    = stop_r;
    total_nxt   = total_r;
    number_nxt  = number_r;
    size_nxt    = size_r;
    clip_nxt    = clip_r;
    left_nxt    = left_r;
    emit        = 1'b0;
    okind_nxt   = okind_r;
    obyte_nxt   = obyte_r;
    olast_nxt   = olast_r;
    if (accept) begin
      phase_nxt  = e_phase;
      stop_nxt   = e_stop;
      total_nxt  = e_total;
      number_nxt = e_number;
      size_nxt   = e_size;
      clip_nxt   = e_clip;
      left_nxt   = e_left;
      case (e_phase)
        PH_TOTAL, PH_NUMBER: begin
          if (is_colon) begin
            phase_nxt = (e_phase == PH_TOTAL) ? PH_NUMBER : PH_SIZE;
            stop_nxt  = 1'b0;
          end else if (!e_stop) begin
            if (!is_digit) begin
              stop_nxt = 1'b1;
            end else if (e_phase == PH_TOTAL) begin
              total_nxt = acc_new;
            end else begin
              number_nxt = acc_new;
            end
          end
        end
        PH_SIZE: begin
          if (is_colon) begin
            phase_nxt = PH_NAME;
            stop_nxt  = 1'b0;
            left_nxt  = e_size;
            emit      = 1'b1;
            okind_nxt = KIND_HEADER;
            obyte_nxt = '0;
            olast_nxt = 1'b0;
          end else if (!e_stop) begin
            if (!is_digit) begin
              stop_nxt = 1'b1;
            end else begin
              size_nxt = size_new;
              if (size_over) begin
                clip_nxt = 1'b1;
              end
            end
          end
        end
        PH_NAME: begin
          if (is_colon) begin
            if (e_left == '0) begin
              phase_nxt = PH_DONE;
              emit      = 1'b1;
              okind_nxt = KIND_DATA;
              obyte_nxt = '0;
              olast_nxt = 1'b1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end else begin
            emit      = 1'b1;
            okind_nxt = KIND_NAME;
            obyte_nxt = b;
            olast_nxt = 1'b0;
          end
        end
        PH_DATA: begin
          if (e_left == '0) begin
            phase_nxt = PH_DONE;
          end else begin
            left_nxt  = left_dec;
            emit      = 1'b1;
            okind_nxt = KIND_DATA;
            obyte_nxt = b;
            olast_nxt = (left_dec == '0);
            if (left_dec == '0) begin
              phase_nxt = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
    ov_nxt      = (ov_r && !out_ch.ready) || emit;
    ototal_nxt  = emit ? e_total  : ototal_r;
    onumber_nxt = emit ? e_number : onumber_r;
    osize_nxt   = emit ? e_size   : osize_r;
    oclip_nxt   = emit ? e_clip   : oclip_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TOTAL;
      stop_r   <= 1'b0;
      total_r  <= '0;
      number_r <= '0;
      size_r   <= '0;
      clip_r   <= 1'b0;
      left_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      stop_r   <= stop_nxt;
      total_r  <= total_nxt;
      number_r <= number_nxt;
      size_r   <= size_nxt;
      clip_r   <= clip_nxt;
      left_r   <= left_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    okind_r   <= okind_nxt;
    ototal_r  <= ototal_nxt;
    onumber_r <= onumber_nxt;
    osize_r   <= osize_nxt;
    oclip_r   <= oclip_nxt;
    obyte_r   <= obyte_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.item_kind       = okind_r;
  assign out_ch.total_frags     = ototal_r;
  assign out_ch.fragment_number = onumber_r;
  assign out_ch.payload_size    = osize_r;
  assign out_ch.size_clipped    = oclip_r;
  assign out_ch.item_byte       = obyte_r;
  assign out_ch.last_of_packet  = olast_r;

  `CFHP_ASSERT(a_data_left_nonzero, clk, rst_n, (phase_r == PH_DATA) |-> (left_r != '0))
  `CFHP_ASSERT(a_left_in_range, clk, rst_n, left_r <= SIZE_MAX)
  `CFHP_ASSERT(a_clip_at_max, clk, rst_n, clip_r |-> (size_r == SIZE_MAX))
  `CFHP_ASSERT(a_name_not_last, clk, rst_n, (ov_r && okind_r == KIND_NAME) |-> !olast_r)

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking bench for colon_fragment_header_parser: random datagrams, idles and stalls
// a small scoreboard class predicts each parse result from the accepted bytes
// depends on cfhp_pkg, cfhp_if.sv and the parser top level
import cfhp_pkg::*;

typedef struct packed {
  kind_t               kind;
  logic [ACC_W-1:0]    total;
  logic [ACC_W-1:0]    number;
  logic [SIZE_W-1:0]   size;
  logic                clipped;
  logic [BYTE_W-1:0]   item_byte;
  logic                last;
} frag_item_t;

class frag_scoreboard;
  phase_t      ph;
  bit          stopped;
  int unsigned total_acc;
  int unsigned number_acc;
  int unsigned size_acc;
  bit          clip;
  int unsigned data_left;
  frag_item_t  expected_items[$];
  int unsigned mismatches;
  int unsigned parsed_bytes;

  function new();
    restart();
    mismatches = 0;
    parsed_bytes = 0;
  endfunction

  function void restart();
    ph = PH_TOTAL;
    stopped = 0;
    total_acc = 0;
    number_acc = 0;
    size_acc = 0;
    clip = 0;
    data_left = 0;
  endfunction

  function bit next_digit(logic [BYTE_W-1:0] b, output int unsigned d);
    d = 0;
    if (stopped) return 0;
    if (b < DIGIT_LO || b > DIGIT_HI) begin
      stopped = 1;
      return 0;
    end
    d = b - DIGIT_LO;
    return 1;
  endfunction

  function int unsigned sat16(int unsigned acc, int unsigned d);
    int unsigned v;
    v = acc * 10 + d;
    return (v > ACC_MAX) ? ACC_MAX : v;
  endfunction

  function void push(kind_t k, logic [BYTE_W-1:0] b, bit last);
    frag_item_t it;
    it.kind = k;
    it.total = ACC_W'(total_acc);
    it.number = ACC_W'(number_acc);
    it.size = SIZE_W'(size_acc);
    it.clipped = clip;
    it.item_byte = b;
    it.last = last;
    expected_items.push_back(it);
  endfunction

  function void note_byte(logic [BYTE_W-1:0] b, bit st);
    int unsigned d;
    int unsigned v;
    if (st) restart();
    parsed_bytes++;
    case (ph)
      PH_TOTAL: begin
        if (b == COLON_BYTE) begin
          ph = PH_NUMBER;
          stopped = 0;
        end else if (next_digit(b, d)) begin
          total_acc = sat16(total_acc, d);
        end
      end
      PH_NUMBER: begin
        if (b == COLON_BYTE) begin
          ph = PH_SIZE;
          stopped = 0;
        end else if (next_digit(b, d)) begin
          number_acc = sat16(number_acc, d);
        end
      end
      PH_SIZE: begin
        if (b == COLON_BYTE) begin
          ph = PH_NAME;
          stopped = 0;
          data_left = size_acc;
          push(KIND_HEADER, '0, 1'b0);
        end else if (next_digit(b, d)) begin
          v = size_acc * 10 + d;
          if (v > MAX_PAYLOAD) begin
            v = MAX_PAYLOAD;
            clip = 1;
          end
          size_acc = v;
        end
      end
      PH_NAME: begin
        if (b == COLON_BYTE) begin
          if (data_left == 0) begin
            ph = PH_DONE;
            push(KIND_DATA, '0, 1'b1);
          end else begin
            ph = PH_DATA;
          end
        end else begin
          push(KIND_NAME, b, 1'b0);
        end
      end
      PH_DATA: begin
        if (data_left == 0) begin
          ph = PH_DONE;
        end else begin
          data_left--;
          push(KIND_DATA, b, data_left == 0);
          if (data_left == 0) ph = PH_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function void cmp(string field, logic [ACC_W-1:0] want, logic [ACC_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endfunction

  function void check_item(frag_item_t got);
    frag_item_t want;
    if (expected_items.size() == 0) begin
      $error("item_kind: expected no result, actual %0d", got.kind);
      mismatches++;
      return;
    end
    want = expected_items.pop_front();
    cmp("item_kind", want.kind, got.kind);
    cmp("total_frags", want.total, got.total);
    cmp("fragment_number", want.number, got.number);
    cmp("payload_size", want.size, got.size);
    cmp("size_clipped", want.clipped, got.clipped);
    cmp("item_byte", want.item_byte, got.item_byte);
    cmp("last_of_packet", want.last, got.last);
  endfunction

  function int unsigned pending();
    return expected_items.size();
  endfunction
endclass

module tb_top;
  logic clk;
  logic rst_n;

  cfhp_in_if  in_ch();
  cfhp_out_if out_ch();

  colon_fragment_header_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frag_scoreboard sb = new();
  bit             no_idle = 0;
  logic [7:0]     frame[$];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("tb_top: done, errors");
    $finish;
  end

  // beat monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte, in_ch.packet_start);
      if (out_ch.valid && out_ch.ready)
        sb.check_item(frag_item_t'{out_ch.item_kind, out_ch.total_frags,
                                   out_ch.fragment_number, out_ch.payload_size,
                                   out_ch.size_clipped, out_ch.item_byte,
                                   out_ch.last_of_packet});
    end
  end

  // result side stalls
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  task automatic send_byte(logic [7:0] b, bit st);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.packet_start <= st;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic send_frame(bit first_start);
    foreach (frame[i]) send_byte(frame[i], (i == 0) ? first_start : 1'b0);
    frame = {};
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endfunction

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == COLON_BYTE || (b >= DIGIT_LO && b <= DIGIT_HI));
    return b;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == COLON_BYTE);
    return b;
  endfunction

  function automatic void add_field(int unsigned v);
    int unsigned n;
    case ($urandom_range(0, 9))
      5: add_text($sformatf("%0d", $urandom));
      6: ;
      7: begin
        add_text($sformatf("%0d", v));
        frame.push_back(junk_byte());
        n = $urandom_range(0, 3);
        repeat (n) frame.push_back(plain_byte());
      end
      8: begin
        frame.push_back(junk_byte());
        add_text($sformatf("%0d", v));
      end
      9: add_text($sformatf("000%0d", v));
      default: add_text($sformatf("%0d", v));
    endcase
  endfunction

  function automatic void add_colon();
    if ($urandom_range(0, 19) != 0) frame.push_back(COLON_BYTE);
  endfunction

  task automatic send_datagram();
    int unsigned sz;
    int unsigned n;
    int unsigned r;
    bit          big;
    add_field(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20));
    add_colon();
    add_field(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20));
    add_colon();
    r = $urandom_range(0, 59);
    big = (r == 0);
    sz = big ? $urandom_range(990, 1023) : (r < 8) ? 0 : $urandom_range(1, 12);
    add_field(sz);
    add_colon();
    n = $urandom_range(0, 4);
    repeat (n) frame.push_back(plain_byte());
    add_colon();
    n = (sz > MAX_PAYLOAD) ? MAX_PAYLOAD : sz;
    r = $urandom_range(0, 9);
    if (big && $urandom_range(0, 1) == 0) n = $urandom_range(0, 20);
    else if (r < 2) n = $urandom_range(0, n);
    else if (r == 2) n += $urandom_range(1, 3);
    repeat (n) frame.push_back(8'($urandom_range(0, 255)));
    send_frame($urandom_range(0, 9) != 0);
  endtask

  initial begin
    int unsigned count;
    int unsigned n;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.packet_start <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // no start after reset, zero size with a name byte, trailing byte ignored
    add_text("1:2:0:");
    frame.push_back(8'hFF);
    frame.push_back(COLON_BYTE);
    frame.push_back(8'h00);
    send_frame(1'b0);
    // junk before digits, saturated number, clipped size, truncated data
    add_text("x5:65536:1001::");
    frame.push_back(8'h00);
    send_frame(1'b1);

    count = 0;
    while (sb.parsed_bytes < 1250) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (count % 16 == 0) drain();
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        send_datagram();
      end
      count++;
    end
    no_idle = 0;

    drain();
    repeat (5) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/cfhp_pkg.sv
sv/cfhp_if.sv
sv/colon_fragment_header_parser.sv
tb/sv/tb_top.sv
